[hw/rtl/ordered_list_engine_macros.svh]
// Assertion macros shared by the ordered list engine RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication.
`define OLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define OLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/olst_pkg.sv]
// Package for the ordered list engine: item structs, codes, FSM states.
// No dependencies.
package olst_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int HANDLE_WIDTH_DEF = 32;
  localparam int MAX_AW           = 12;
  localparam int MAX_HW           = 64;

  typedef enum logic [3:0] {
    FN_APPEND        = 4'd0,
    FN_INSERT_AT     = 4'd1,
    FN_REMOVE_AT     = 4'd2,
    FN_REMOVE_LAST   = 4'd3,
    FN_REPLACE_AT    = 4'd4,
    FN_INDEX_OF      = 4'd5,
    FN_ADD_IF_ABSENT = 4'd6,
    FN_REMOVE_VALUE  = 4'd7,
    FN_REPLACE_VALUE = 4'd8,
    FN_READ_AT       = 4'd9,
    FN_READ_LAST     = 4'd10,
    FN_CLEAR         = 4'd11,
    FN_REVERSE       = 4'd12
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_PRESENT  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SHUP, S_SHDN, S_RD, S_WR, S_REV, S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  position;
    logic [31:0] handle;
    logic [31:0] new_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] old_handle;
    logic [6:0]  found_index;
    logic [6:0]  length;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [MAX_AW-1:0] waddr;
    logic [MAX_HW-1:0] wdata;
    logic              re;
    logic [MAX_AW-1:0] raddr;
  } mem_req_t;

endpackage

[hw/rtl/olst_mem.sv]
// Slot store of the ordered list engine: one write port, one read port,
// registered read data. Depends on olst_pkg.
module olst_mem #(
  parameter int DEPTH = olst_pkg::CAPACITY_DEF,
  parameter int WIDTH = olst_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  olst_pkg::mem_req_t   req,
  output logic [WIDTH-1:0]     rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      slots_r[req.waddr[AW-1:0]] <= req.wdata[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= slots_r[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;
endmodule

[hw/rtl/olst_ctrl.sv]
// Sequencer of the ordered list engine: decodes an item, walks the slot
// store, holds count and result. Depends on olst_pkg and the macro header.
`include "ordered_list_engine_macros.svh"

module olst_ctrl #(
  parameter int CAPACITY     = olst_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = olst_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  olst_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output olst_pkg::out_item_t     out_data,
  output olst_pkg::mem_req_t      mem_req,
  input  logic [HANDLE_WIDTH-1:0] mem_rdata
);
  localparam int HW = HANDLE_WIDTH;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CW = CW'(1);

  olst_pkg::state_t  state_r, state_nxt;
  olst_pkg::status_t status_r, status_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [3:0]    func_r, func_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [HW-1:0] nh_r, nh_nxt;
  logic [HW-1:0] old_r, old_nxt;
  logic [HW-1:0] tmp_r, tmp_nxt;
  logic          out_valid_r, out_valid_nxt;
  olst_pkg::out_item_t out_data_r, out_data_nxt;

  logic [63:0]   h64, nh64, old64;
  logic [HW-1:0] h_in, nh_in;
  logic [PW-1:0] pos_ext, used_ext;
  logic [CW-1:0] pos_cw, rp_inc, used_dec, hi_dec;
  logic          pos_lt, full, more, hit, ins_shift, out_free;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [HW-1:0] wd;

  assign h64       = {32'd0, in_data.handle};
  assign nh64      = {32'd0, in_data.new_handle};
  assign h_in      = h64[HW-1:0];
  assign nh_in     = nh64[HW-1:0];
  assign pos_ext   = PW'(in_data.position);
  assign used_ext  = PW'(used_r);
  assign pos_lt    = pos_ext < used_ext;
  assign pos_cw    = CW'(in_data.position);
  assign full      = used_r == CAP_CW;
  assign rp_inc    = rp_r + ONE_CW;
  assign used_dec  = used_r - ONE_CW;
  assign hi_dec    = hi_r - ONE_CW;
  assign more      = rp_inc < used_r;
  assign hit       = (rp_r < used_r) && (mem_rdata == h_r);
  assign ins_shift = (in_data.func == olst_pkg::FN_INSERT_AT) && pos_lt;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == olst_pkg::S_IDLE;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olst_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            olst_pkg::FN_APPEND, olst_pkg::FN_INSERT_AT: begin
              if (h_in == '0 || full) state_nxt = olst_pkg::S_DONE;
              else if (ins_shift)     state_nxt = olst_pkg::S_SHUP;
              else                    state_nxt = olst_pkg::S_WR;
            end
            olst_pkg::FN_ADD_IF_ABSENT, olst_pkg::FN_INDEX_OF,
            olst_pkg::FN_REMOVE_VALUE, olst_pkg::FN_REPLACE_VALUE:
              state_nxt = (h_in == '0) ? olst_pkg::S_DONE : olst_pkg::S_SRCH;
            olst_pkg::FN_REMOVE_AT:
              state_nxt = pos_lt ? olst_pkg::S_SHDN : olst_pkg::S_DONE;
            olst_pkg::FN_REMOVE_LAST, olst_pkg::FN_READ_LAST:
              state_nxt = (used_r != '0) ? olst_pkg::S_RD : olst_pkg::S_DONE;
            olst_pkg::FN_REPLACE_AT:
              state_nxt = (h_in != '0 && pos_lt) ? olst_pkg::S_RD : olst_pkg::S_DONE;
            olst_pkg::FN_READ_AT:
              state_nxt = pos_lt ? olst_pkg::S_RD : olst_pkg::S_DONE;
            olst_pkg::FN_REVERSE:
              state_nxt = (used_r > ONE_CW) ? olst_pkg::S_REV : olst_pkg::S_DONE;
            default: state_nxt = olst_pkg::S_DONE;
          endcase
        end
      end
      olst_pkg::S_SRCH: begin
        if (hit) begin
          state_nxt = (func_r == olst_pkg::FN_REMOVE_VALUE) ? olst_pkg::S_SHDN
                                                             : olst_pkg::S_DONE;
        end else if (!more) begin
          state_nxt = (func_r == olst_pkg::FN_ADD_IF_ABSENT && !full) ? olst_pkg::S_WR
                                                                       : olst_pkg::S_DONE;
        end
      end
      olst_pkg::S_SHUP: if (rp_r <= idx_r) state_nxt = olst_pkg::S_WR;
      olst_pkg::S_SHDN: if (!more) state_nxt = olst_pkg::S_DONE;
      olst_pkg::S_RD:   state_nxt = olst_pkg::S_DONE;
      olst_pkg::S_WR:   state_nxt = olst_pkg::S_DONE;
      olst_pkg::S_REV: begin
        if (phase_r == 2'd3 && !(rp_inc < hi_dec)) state_nxt = olst_pkg::S_DONE;
      end
      olst_pkg::S_DONE: if (out_free) state_nxt = olst_pkg::S_IDLE;
      default: state_nxt = olst_pkg::S_IDLE;
    endcase
  end

  // Datapath and store requests.
  always_comb begin
    status_nxt    = status_r;
    used_nxt      = used_r;
    rp_nxt        = rp_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    phase_nxt     = phase_r;
    func_nxt      = func_r;
    h_nxt         = h_r;
    nh_nxt        = nh_r;
    old_nxt       = old_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    wd = h_r;
    unique case (state_r)
      olst_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_data.func;
          h_nxt      = h_in;
          nh_nxt     = nh_in;
          status_nxt = olst_pkg::ST_OK;
          old_nxt    = '0;
          idx_nxt    = CAP_CW;
          unique case (in_data.func)
            olst_pkg::FN_APPEND, olst_pkg::FN_INSERT_AT: begin
              if (h_in == '0) status_nxt = olst_pkg::ST_ZERO;
              else if (full)  status_nxt = olst_pkg::ST_FULL;
              else if (ins_shift) begin
                idx_nxt = pos_cw;
                re      = 1'b1;
                ra      = used_dec[AW-1:0];
                rp_nxt  = used_dec;
              end else begin
                idx_nxt = used_r;
              end
            end
            olst_pkg::FN_ADD_IF_ABSENT, olst_pkg::FN_INDEX_OF,
            olst_pkg::FN_REMOVE_VALUE, olst_pkg::FN_REPLACE_VALUE: begin
              if (h_in == '0) status_nxt = olst_pkg::ST_ZERO;
              else begin
                re     = 1'b1;
                rp_nxt = '0;
              end
            end
            olst_pkg::FN_REMOVE_AT, olst_pkg::FN_READ_AT: begin
              if (!pos_lt) status_nxt = olst_pkg::ST_BADIDX;
              else begin
                idx_nxt = pos_cw;
                re      = 1'b1;
                ra      = pos_cw[AW-1:0];
                rp_nxt  = pos_cw;
              end
            end
            olst_pkg::FN_REMOVE_LAST, olst_pkg::FN_READ_LAST: begin
              if (used_r == '0) status_nxt = olst_pkg::ST_BADIDX;
              else begin
                idx_nxt = used_dec;
                re      = 1'b1;
                ra      = used_dec[AW-1:0];
                if (in_data.func == olst_pkg::FN_REMOVE_LAST) used_nxt = used_dec;
              end
            end
            olst_pkg::FN_REPLACE_AT: begin
              if (h_in == '0)   status_nxt = olst_pkg::ST_ZERO;
              else if (!pos_lt) status_nxt = olst_pkg::ST_BADIDX;
              else begin
                idx_nxt = pos_cw;
                re      = 1'b1;
                ra      = pos_cw[AW-1:0];
              end
            end
            olst_pkg::FN_CLEAR: used_nxt = '0;
            olst_pkg::FN_REVERSE: begin
              rp_nxt    = '0;
              hi_nxt    = used_dec;
              phase_nxt = 2'd0;
            end
            default: ;
          endcase
        end
      end
      olst_pkg::S_SRCH: begin
        if (hit) begin
          idx_nxt = rp_r;
          case (func_r)
            olst_pkg::FN_ADD_IF_ABSENT: status_nxt = olst_pkg::ST_PRESENT;
            olst_pkg::FN_REMOVE_VALUE: begin
              re = 1'b1;
              ra = rp_r[AW-1:0];
            end
            olst_pkg::FN_REPLACE_VALUE: begin
              if (nh_r == '0) begin
                status_nxt = olst_pkg::ST_ZERO;
                idx_nxt    = CAP_CW;
              end else begin
                old_nxt = h_r;
                we      = 1'b1;
                wa      = rp_r[AW-1:0];
                wd      = nh_r;
              end
            end
            default: ;
          endcase
        end else if (more) begin
          re     = 1'b1;
          ra     = rp_inc[AW-1:0];
          rp_nxt = rp_inc;
        end else if (func_r == olst_pkg::FN_ADD_IF_ABSENT) begin
          if (full) status_nxt = olst_pkg::ST_FULL;
          else      idx_nxt    = used_r;
        end else begin
          status_nxt = olst_pkg::ST_NOTFOUND;
        end
      end
      olst_pkg::S_SHUP: begin
        // move one element up, then fetch the one below it
        we = 1'b1;
        wa = rp_inc[AW-1:0];
        wd = mem_rdata;
        if (rp_r > idx_r) begin
          re     = 1'b1;
          ra     = rp_r[AW-1:0] - 1'b1;
          rp_nxt = rp_r - ONE_CW;
        end
      end
      olst_pkg::S_SHDN: begin
        if (rp_r == idx_r) old_nxt = mem_rdata;
        else begin
          we = 1'b1;
          wa = rp_r[AW-1:0] - 1'b1;
          wd = mem_rdata;
        end
        if (more) begin
          re     = 1'b1;
          ra     = rp_inc[AW-1:0];
          rp_nxt = rp_inc;
        end else begin
          used_nxt = used_dec;
        end
      end
      olst_pkg::S_RD: begin
        old_nxt = mem_rdata;
        if (func_r == olst_pkg::FN_REPLACE_AT) begin
          we = 1'b1;
          wa = idx_r[AW-1:0];
          wd = h_r;
        end
      end
      olst_pkg::S_WR: begin
        we       = 1'b1;
        wa       = idx_r[AW-1:0];
        wd       = h_r;
        used_nxt = used_r + ONE_CW;
      end
      olst_pkg::S_REV: begin
        phase_nxt = phase_r + 2'd1;
        case (phase_r)
          2'd0: begin
            re = 1'b1;
            ra = rp_r[AW-1:0];
          end
          2'd1: begin
            tmp_nxt = mem_rdata;
            re      = 1'b1;
            ra      = hi_r[AW-1:0];
          end
          2'd2: begin
            we = 1'b1;
            wa = rp_r[AW-1:0];
            wd = mem_rdata;
          end
          default: begin
            we     = 1'b1;
            wa     = hi_r[AW-1:0];
            wd     = tmp_r;
            rp_nxt = rp_inc;
            hi_nxt = hi_dec;
          end
        endcase
      end
      olst_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.old_handle  = old64[31:0];
          out_data_nxt.found_index = 7'(idx_r);
          out_data_nxt.length      = 7'(used_r);
        end
      end
      default: ;
    endcase
  end

  assign old64 = 64'(old_r);

  assign mem_req = '{we:    we,
                     waddr: olst_pkg::MAX_AW'(wa),
                     wdata: olst_pkg::MAX_HW'(wd),
                     re:    re,
                     raddr: olst_pkg::MAX_AW'(ra)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olst_pkg::S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    rp_r       <= rp_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    func_r     <= func_nxt;
    h_r        <= h_nxt;
    nh_r       <= nh_nxt;
    old_r      <= old_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OLE_ASSERT_IMP(a_used_cap, 1'b1, used_r <= CAP_CW, "count above capacity")
  `OLE_ASSERT_IMP(a_shdn_range, state_r == olst_pkg::S_SHDN, rp_r < used_r, "shift past end")
  `OLE_ASSERT_NXT(a_wr_grow, state_r == olst_pkg::S_WR, used_r == $past(used_r) + ONE_CW, "write did not grow count")
  `OLE_ASSERT_NXT(a_done_out, state_r == olst_pkg::S_DONE && out_free, out_valid, "result not presented")
endmodule

[hw/rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: sequencer plus slot store.
// Depends on olst_pkg, olst_ctrl and olst_mem.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | in_data  (func, position, handle, new_handle)
//  result   | out_valid/out_ready  | out_data (status, old_handle, found_index, length)
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Search, insert and remove walk the list one slot at a time through the single
// read port; reverse makes two reads and two writes per pair.
// Reset (synchronous, rst_n low) empties the list; slot contents stay stale.
// The result register frees the input side: the next item is taken while a
// result still waits on out_ready.
module ordered_list_engine #(
  parameter int CAPACITY     = olst_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = olst_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  olst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output olst_pkg::out_item_t out_data
);
  // store request from the sequencer, read data back in the next cycle
  olst_pkg::mem_req_t      mem_req;
  logic [HANDLE_WIDTH-1:0] mem_rdata;

  olst_ctrl #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // slots hold the list elements in order at indices 0..length-1
  olst_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (HANDLE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );
endmodule
